// ===== rtl/core/integer_to_ascii_digits_unit_assert.svh =====
// Assertion macros shared by the integer-to-ASCII unit.
`ifndef INTEGER_TO_ASCII_DIGITS_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_DIGITS_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ITOA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("itoa assertion failed");

// Next-cycle implication, checked out of reset.
`define ITOA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("itoa assertion failed");

`endif

// ===== rtl/core/itoa_pkg.sv =====
// Shared types, constants and glyph lookup for the integer-to-ASCII unit.
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int ValueWidth     = 32;
  localparam int DigitCount     = 10;
  localparam int DigitIdxWidth  = $clog2(DigitCount);
  localparam int StepCountWidth = $clog2(ValueWidth + 1);

  localparam logic [7:0] MinusChar = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } itoa_state_e;

  typedef logic [DigitCount-1:0][3:0] itoa_digits_t;

  typedef struct packed {
    logic                  start;
    logic                  hex;
    logic [ValueWidth-1:0] mag;
  } itoa_cmd_t;

  typedef struct packed {
    logic         done;
    itoa_digits_t digits;
  } itoa_status_t;

  function automatic logic [7:0] digit_glyph(input logic [3:0] nib);
    logic [7:0] ch;
    case (nib)
      4'h0: ch = 8'h30;
      4'h1: ch = 8'h31;
      4'h2: ch = 8'h32;
      4'h3: ch = 8'h33;
      4'h4: ch = 8'h34;
      4'h5: ch = 8'h35;
      4'h6: ch = 8'h36;
      4'h7: ch = 8'h37;
      4'h8: ch = 8'h38;
      4'h9: ch = 8'h39;
      4'hA: ch = 8'h41;
      4'hB: ch = 8'h42;
      4'hC: ch = 8'h43;
      4'hD: ch = 8'h44;
      4'hE: ch = 8'h45;
      default: ch = 8'h46;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/core/itoa_dabble.sv =====
// Shift-and-add-3 binary to BCD converter, one bit per cycle; hex loads directly.
`timescale 1ns / 1ps

module itoa_dabble (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itoa_pkg::itoa_cmd_t  cmd_i,
  output itoa_pkg::itoa_status_t status_o
);

  logic [itoa_pkg::ValueWidth-1:0]     bin_q, bin_d;
  itoa_pkg::itoa_digits_t              bcd_q, bcd_d;
  logic [itoa_pkg::StepCountWidth-1:0] cnt_q, cnt_d;
  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  itoa_pkg::itoa_digits_t              adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < itoa_pkg::DigitCount; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      if (cmd_i.hex) begin
        bcd_d  = itoa_pkg::itoa_digits_t'(
                   {{(itoa_pkg::DigitCount * 4 - itoa_pkg::ValueWidth){1'b0}}, cmd_i.mag});
        done_d = 1'b1;
      end else begin
        bin_d  = cmd_i.mag;
        bcd_d  = '0;
        cnt_d  = itoa_pkg::StepCountWidth'(itoa_pkg::ValueWidth);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      {bcd_d, bin_d} = {adj, bin_q} << 1;
      cnt_d          = cnt_q - 1'b1;
      if (cnt_q == itoa_pkg::StepCountWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign status_o.done   = done_q;
  assign status_o.digits = bcd_q;

endmodule

// ===== rtl/core/integer_to_ascii_digits_unit.sv =====
// Top level: converts a 32-bit word to ASCII decimal or hex text, one character per transfer.
//
//  channel | dir | tdata                  | tuser                         | tlast
//  s_axis  | in  | [31:0] value_word      | [0] hex_base, [1] signed_mode | -
//  m_axis  | out | [7:0]  out_char        | -                             | last_char
//
// Decimal: the word is accepted, run through 32 shift-add-3 steps and its digits collected;
// leading zeros are then skipped one at a time (up to 9) until the first digit is found,
// and the characters are sent, one per transfer. Hex loads directly and skips the shift steps.
// s_axis_tready_o is high only while idle; the last character may still wait
// in the output register while the next word is taken.
// Reset clears the sequencer and the output valid; m_axis stalls hold the sequencer in its sign and emit states.
`timescale 1ns / 1ps

module integer_to_ascii_digits_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value_word
  input  logic [1:0]  s_axis_tuser_i,   // [0] hex_base, [1] signed_mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_char
  output logic        m_axis_tlast_o    // last_char
);

  itoa_pkg::itoa_state_e              state_q, state_d;
  logic [itoa_pkg::DigitIdxWidth-1:0] ptr_q, ptr_d;
  logic                               neg_q, neg_d;
  logic                               out_valid_q, out_valid_d;
  logic [7:0]                         out_char_q, out_char_d;
  logic                               out_last_q, out_last_d;
  itoa_pkg::itoa_cmd_t                cmd;
  itoa_pkg::itoa_status_t             status;
  logic                               in_xfer;
  logic                               out_free;
  logic                               neg_in;
  logic [3:0]                         cur_digit;

  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign neg_in    = s_axis_tuser_i[1] && s_axis_tdata_i[31];
  assign cur_digit = status.digits[ptr_q];

  assign cmd.start = in_xfer;
  assign cmd.hex   = s_axis_tuser_i[0];
  assign cmd.mag   = neg_in ? (~s_axis_tdata_i + 32'd1) : s_axis_tdata_i;

  itoa_dabble u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      itoa_pkg::ST_IDLE: if (in_xfer) state_d = itoa_pkg::ST_CONV;
      itoa_pkg::ST_CONV: begin
        if (status.done) state_d = neg_q ? itoa_pkg::ST_SIGN : itoa_pkg::ST_SKIP;
      end
      itoa_pkg::ST_SIGN: if (out_free) state_d = itoa_pkg::ST_SKIP;
      itoa_pkg::ST_SKIP: begin
        if (cur_digit != 4'd0 || ptr_q == '0) state_d = itoa_pkg::ST_EMIT;
      end
      itoa_pkg::ST_EMIT: if (out_free && ptr_q == '0) state_d = itoa_pkg::ST_IDLE;
      default: state_d = itoa_pkg::ST_IDLE;
    endcase
  end

  // datapath and output register control
  always_comb begin
    ptr_d       = ptr_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    s_axis_tready_o = 1'b0;
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) neg_d = neg_in;
      end
      itoa_pkg::ST_CONV: begin
        ptr_d = itoa_pkg::DigitIdxWidth'(itoa_pkg::DigitCount - 1);
      end
      itoa_pkg::ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = itoa_pkg::MinusChar;
          out_last_d  = 1'b0;
        end
      end
      itoa_pkg::ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (cur_digit == 4'd0 && ptr_q != '0) ptr_d = ptr_q - 1'b1;
      end
      itoa_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = itoa_pkg::digit_glyph(cur_digit);
          out_last_d  = (ptr_q == '0);
          if (ptr_q != '0) ptr_d = ptr_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itoa_pkg::ST_IDLE;
      ptr_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;

`include "integer_to_ascii_digits_unit_assert.svh"

  `ITOA_ASSERT_NEXT(a_busy_after_accept, in_xfer, !s_axis_tready_o)
  `ITOA_ASSERT_NOW(a_done_only_in_conv, status.done, state_q == itoa_pkg::ST_CONV)
  `ITOA_ASSERT_NEXT(a_last_ends_item,
                    state_q == itoa_pkg::ST_EMIT && out_free && ptr_q == '0,
                    state_q == itoa_pkg::ST_IDLE && m_axis_tvalid_o && m_axis_tlast_o)

endmodule
